### rtl/owlm_pkg.sv
// ----------------------------------------------------------------------------
// owlm_pkg
// Shared types, codes and CRC helpers for the single-wire LCD session master.
// ----------------------------------------------------------------------------
package owlm_pkg;

    // Function codes carried in each input word.
    localparam logic [1:0] FUNC_TICK      = 2'd0;
    localparam logic [1:0] FUNC_INFO      = 2'd1;
    localparam logic [1:0] FUNC_BACKLIGHT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RESET_HIGH = 2'd0;
    localparam logic [1:0] CFG_START_LOW  = 2'd1;
    localparam logic [1:0] CFG_MAX_ATT    = 2'd2;
    localparam logic [1:0] CFG_CRC_SEED   = 2'd3;

    localparam logic [5:0] RESET_HIGH_DEF = 6'd60;
    localparam logic [3:0] START_LOW_DEF  = 4'd2;
    localparam logic [2:0] MAX_ATT_DEF    = 3'd3;
    localparam logic [7:0] CRC_SEED_DEF   = 8'hAC;

    localparam logic [7:0] CRC_POLY       = 8'h07;
    localparam logic [7:0] INFO_CMD_BYTE  = 8'h60;
    localparam logic [7:0] REQ_BL_FLAG    = 8'h80;
    localparam logic [7:0] BRIGHT_MAX     = 8'd127;
    localparam logic [5:0] FRAME_BITS     = 6'd16;
    localparam logic [5:0] RX_BITS        = 6'd32;
    localparam logic [14:0] FW_MAJOR_MUL  = 15'd100;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HIGH   = 3'd1,
        PH_LOW    = 3'd2,
        PH_SEND   = 3'd3,
        PH_HOLD   = 3'd4,
        PH_REL    = 3'd5,
        PH_SAMPLE = 3'd6
    } t_phase;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] brightness;
        logic       pin_level;
    } t_in_word;

    typedef struct packed {
        logic        line_drive;
        logic        line_output_enable;
        logic        busy_res;
        logic        done_res;
        logic        success;
        logic [31:0] raw_response;
        logic [7:0]  lcd_type;
        logic [14:0] firmware_version;
    } t_out_word;

    typedef struct packed {
        logic [5:0] reset_high_ticks;
        logic [3:0] start_low_ticks;
        logic [2:0] max_attempts;
        logic [7:0] crc_seed;
    } t_cfg;

    // One MSB-first CRC-8 step.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic din);
        logic fb;
        fb = crc[7] ^ din;
        crc8_step = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] crc8_byte(input logic [7:0] seed, input logic [7:0] data);
        logic [7:0] crc;
        crc = seed;
        for (int i = 7; i >= 0; i--) begin
            crc = crc8_step(crc, data[i]);
        end
        crc8_byte = crc;
    endfunction

    // CRC over the 24-bit body of a reply; the unrolled loop is a flat XOR network.
    function automatic logic [7:0] crc8_body(input logic [7:0] seed, input logic [23:0] data);
        logic [7:0] crc;
        crc = seed;
        for (int i = 23; i >= 0; i--) begin
            crc = crc8_step(crc, data[i]);
        end
        crc8_body = crc;
    endfunction

endpackage

### rtl/owlm_core.sv
// ----------------------------------------------------------------------------
// owlm_core
// Session state and one-word update: line timing, frame shift-out, response
// shift-in with the CRC check of each reply, retry count and the result of
// each word.
// ----------------------------------------------------------------------------
module owlm_core
    import owlm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_out_word o_res
);

    t_phase      r_phase,   n_phase;
    logic [5:0]  r_tick,    n_tick;
    logic [7:0]  r_req,     n_req;
    logic [15:0] r_tx,      n_tx;
    logic [31:0] r_rx,      n_rx;
    logic [2:0]  r_attempt, n_attempt;
    logic        r_lvl,     n_lvl;
    logic        r_en,      n_en;

    logic        done;
    logic        ok;
    logic [31:0] resp;
    logic [5:0]  tick_inc;
    logic [5:0]  lim_high;
    logic [5:0]  lim_low;
    logic [2:0]  lim_att;
    logic [7:0]  req;
    logic [15:0] frame;
    logic [14:0] fw;

    assign tick_inc = r_tick + 6'd1;
    assign lim_high = (i_cfg.reset_high_ticks == 6'd0) ? 6'd1 : i_cfg.reset_high_ticks;
    assign lim_low  = (i_cfg.start_low_ticks == 4'd0) ? 6'd1
                                                       : {2'b00, i_cfg.start_low_ticks};
    assign lim_att  = (i_cfg.max_attempts == 3'd0) ? 3'd1 : i_cfg.max_attempts;

    // The request byte is taken from the start word when idle and from the
    // session otherwise; its CRC always uses the current seed.
    always_comb begin
        if (r_phase != PH_IDLE) begin
            req = r_req;
        end else if (i_word.func == FUNC_INFO) begin
            req = INFO_CMD_BYTE;
        end else begin
            req = ((i_word.brightness > BRIGHT_MAX) ? BRIGHT_MAX : i_word.brightness)
                  | REQ_BL_FLAG;
        end
        frame = {req, crc8_byte(i_cfg.crc_seed, req)};
    end

    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_req     = r_req;
        n_tx      = r_tx;
        n_rx      = r_rx;
        n_attempt = r_attempt;
        n_lvl     = r_lvl;
        n_en      = r_en;
        done      = 1'b0;
        ok        = 1'b0;
        resp      = 32'd0;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_word.func == FUNC_INFO || i_word.func == FUNC_BACKLIGHT) begin
                    n_req     = req;
                    n_attempt = 3'd0;
                    n_phase   = PH_HIGH;
                    n_tick    = 6'd0;
                    n_rx      = 32'd0;
                    n_tx      = frame;
                    n_lvl     = 1'b1;
                    n_en      = 1'b1;
                end
            end
            PH_HIGH: begin
                if (i_word.func == FUNC_TICK) begin
                    if (tick_inc >= lim_high) begin
                        n_phase = PH_LOW;
                        n_tick  = 6'd0;
                        n_lvl   = 1'b0;
                    end else begin
                        n_tick  = tick_inc;
                    end
                end
            end
            PH_LOW: begin
                if (i_word.func == FUNC_TICK) begin
                    n_tick = 6'd0;
                    if (tick_inc >= lim_low) begin
                        n_phase = PH_SEND;
                        n_lvl   = r_tx[15];
                        n_tx    = {r_tx[14:0], 1'b0};
                    end else begin
                        n_tick  = tick_inc;
                    end
                end
            end
            PH_SEND: begin
                if (i_word.func == FUNC_TICK) begin
                    if (tick_inc >= FRAME_BITS) begin
                        n_phase = PH_HOLD;
                        n_tick  = 6'd0;
                    end else begin
                        n_tick  = tick_inc;
                        n_lvl   = r_tx[15];
                        n_tx    = {r_tx[14:0], 1'b0};
                    end
                end
            end
            PH_HOLD: begin
                if (i_word.func == FUNC_TICK) begin
                    n_phase = PH_REL;
                    n_tick  = 6'd0;
                    n_en    = 1'b0;
                end
            end
            PH_REL: begin
                if (i_word.func == FUNC_TICK) begin
                    n_phase = PH_SAMPLE;
                    n_tick  = 6'd0;
                end
            end
            PH_SAMPLE: begin
                if (i_word.func == FUNC_TICK) begin
                    n_rx   = {r_rx[30:0], i_word.pin_level};
                    n_tick = tick_inc;
                    if (tick_inc >= RX_BITS) begin
                        n_lvl     = 1'b1;
                        n_en      = 1'b1;
                        // The CRC covers the first 24 received bits.
                        ok        = (crc8_body(i_cfg.crc_seed, n_rx[31:8]) == n_rx[7:0]);
                        n_attempt = r_attempt + 3'd1;
                        if (ok || n_attempt >= lim_att) begin
                            done    = 1'b1;
                            resp    = n_rx;
                            n_phase = PH_IDLE;
                            n_tick  = 6'd0;
                        end else begin
                            // Retry starts on this same tick.
                            n_phase = PH_HIGH;
                            n_tick  = 6'd0;
                            n_rx    = 32'd0;
                            n_tx    = frame;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign fw = ({7'd0, resp[23:16]} * FW_MAJOR_MUL) + {7'd0, resp[15:8]};

    always_comb begin
        o_res.line_drive         = n_lvl;
        o_res.line_output_enable = n_en;
        o_res.busy_res           = (n_phase != PH_IDLE);
        o_res.done_res           = done;
        o_res.success            = done & ok;
        o_res.raw_response       = resp;
        o_res.lcd_type           = resp[31:24];
        o_res.firmware_version   = fw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= 6'd0;
            r_req     <= 8'd0;
            r_tx      <= 16'd0;
            r_rx      <= 32'd0;
            r_attempt <= 3'd0;
            r_lvl     <= 1'b1;
            r_en      <= 1'b1;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_req     <= n_req;
            r_tx      <= n_tx;
            r_rx      <= n_rx;
            r_attempt <= n_attempt;
            r_lvl     <= n_lvl;
            r_en      <= n_en;
        end
    end

endmodule

### rtl/one_wire_lcd_session_master_unit.sv
// ----------------------------------------------------------------------------
// one_wire_lcd_session_master_unit
// Single-wire LCD info/backlight session master advanced by tick words.
//
//   channel  | direction | handshake                 | word
//   ---------+-----------+---------------------------+------------
//   in       | input     | i_in_valid / o_in_stall   | t_in_word
//   out      | output    | o_out_valid / i_out_stall | t_out_word
//   cfg      | input     | i_cfg_we (no wait)        | idx + data
//
// One word is accepted per cycle while o_in_stall is low; its result word
// is valid once it has passed the input register and the state update into
// the result register.
// Reset is synchronous and active low; it restores the default register set
// and an idle session. While a result word waits under i_out_stall, one more
// word enters the input register; after that o_in_stall follows i_out_stall.
// ----------------------------------------------------------------------------
module one_wire_lcd_session_master_unit
    import owlm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_cfg      r_cfg;
    t_out_word res;
    logic      advance;
    logic      accept;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_high_ticks <= RESET_HIGH_DEF;
            r_cfg.start_low_ticks  <= START_LOW_DEF;
            r_cfg.max_attempts     <= MAX_ATT_DEF;
            r_cfg.crc_seed         <= CRC_SEED_DEF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RESET_HIGH: r_cfg.reset_high_ticks <= i_cfg_data[5:0];
                CFG_START_LOW:  r_cfg.start_low_ticks  <= i_cfg_data[3:0];
                CFG_MAX_ATT:    r_cfg.max_attempts     <= i_cfg_data[2:0];
                CFG_CRC_SEED:   r_cfg.crc_seed         <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_word <= i_in_word;
        end
    end

    owlm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_word  (r_in_word),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the single-wire LCD session master. Input words are
// run through a cycle-free model of the session sequencer as they are
// accepted, and every result word is compared field by field with the oldest
// prediction. A short directed list opens the run at the reset settings. Then
// whole sessions follow, with replies that pass or fail the CRC check, under
// several register settings including both extremes. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb;
    import owlm_pkg::*;

    // Function code with no meaning; the block must ignore it.
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        t_in_word  w;
        logic      typed;
        t_out_word want;
    } t_dir_row;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_word   in_word = '0;
    logic       in_stall;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_word  out_word;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_idx = CFG_RESET_HIGH;
    logic [7:0] cfg_data = '0;

    // Session model state and its copy of the register set.
    t_cfg        cfg;
    t_phase      ph;
    logic [5:0]  tcnt;
    logic [7:0]  req;
    logic [15:0] txs;
    logic [31:0] rxs;
    logic [2:0]  att;
    logic        drv;
    logic        den;

    t_out_word   pending_out[$];
    logic [31:0] reply_plan;
    int          word_count = 0;
    int          mismatches = 0;
    int          in_sent = 0;
    int          in_mode = 0;

    one_wire_lcd_session_master_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // CRC-8, polynomial 0x07, MSB first over the top nbits of data.
    function automatic logic [7:0] crc8_msb(input logic [7:0] seed, input logic [31:0] data,
                                            input int nbits);
        logic [7:0] c;
        logic       fb;
        c = seed;
        for (int i = 0; i < nbits; i++) begin
            fb = c[7] ^ data[31 - i];
            c = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
        end
        return c;
    endfunction

    function automatic void start_attempt();
        ph   = PH_HIGH;
        tcnt = '0;
        rxs  = '0;
        txs  = {req, crc8_msb(cfg.crc_seed, {req, 24'h0}, 8)};
        drv  = 1'b1;
        den  = 1'b1;
    endfunction

    function automatic void shift_out_bit();
        drv = txs[15];
        txs = {txs[14:0], 1'b0};
    endfunction

    // Advances the session model by one accepted word and returns its result word.
    function automatic t_out_word step_session(input t_in_word w);
        t_out_word   r;
        logic [5:0]  lim;
        logic [2:0]  alim;
        logic        ok;
        logic        done;
        logic [31:0] resp;
        ok   = 1'b0;
        done = 1'b0;
        resp = '0;
        if (ph == PH_IDLE) begin
            if (w.func == FUNC_INFO || w.func == FUNC_BACKLIGHT) begin
                if (w.func == FUNC_INFO) begin
                    req = 8'h60;
                end else begin
                    req = ((w.brightness > 8'd127) ? 8'd127 : w.brightness) | 8'h80;
                end
                att = '0;
                start_attempt();
            end
        end else if (w.func == FUNC_TICK) begin
            tcnt = tcnt + 6'd1;
            case (ph)
                PH_HIGH: begin
                    lim = (cfg.reset_high_ticks == 0) ? 6'd1 : cfg.reset_high_ticks;
                    if (tcnt >= lim) begin
                        ph   = PH_LOW;
                        tcnt = '0;
                        drv  = 1'b0;
                    end
                end
                PH_LOW: begin
                    lim = (cfg.start_low_ticks == 0) ? 6'd1 : {2'b00, cfg.start_low_ticks};
                    if (tcnt >= lim) begin
                        ph   = PH_SEND;
                        tcnt = '0;
                        shift_out_bit();
                    end
                end
                PH_SEND: begin
                    if (tcnt >= 6'd16) begin
                        ph   = PH_HOLD;
                        tcnt = '0;
                    end else begin
                        shift_out_bit();
                    end
                end
                PH_HOLD: begin
                    ph   = PH_REL;
                    tcnt = '0;
                    den  = 1'b0;
                end
                PH_REL: begin
                    ph   = PH_SAMPLE;
                    tcnt = '0;
                end
                default: begin
                    rxs = {rxs[30:0], w.pin_level};
                    if (tcnt >= 6'd32) begin
                        alim = (cfg.max_attempts == 0) ? 3'd1 : cfg.max_attempts;
                        drv  = 1'b1;
                        den  = 1'b1;
                        ok   = (crc8_msb(cfg.crc_seed, rxs, 24) == rxs[7:0]);
                        att  = att + 3'd1;
                        if (ok || att >= alim) begin
                            done = 1'b1;
                            resp = rxs;
                            ph   = PH_IDLE;
                            tcnt = '0;
                        end else begin
                            start_attempt();
                        end
                    end
                end
            endcase
        end
        r = '0;
        r.line_drive         = drv;
        r.line_output_enable = den;
        r.busy_res           = (ph != PH_IDLE);
        r.done_res           = done;
        r.success            = done & ok;
        r.raw_response       = resp;
        r.lcd_type           = resp[31:24];
        r.firmware_version   = resp[23:16] * 15'd100 + resp[15:8];
        return r;
    endfunction

    // Gap length for one word; mode 0 never idles, mode 2 idles now and then.
    function automatic int draw_wait(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 14);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        endcase
    endfunction

    // Reply for one attempt: about half carry a good CRC byte.
    function automatic logic [31:0] make_reply();
        logic [23:0] body;
        logic [7:0]  crc;
        case ($urandom_range(0, 5))
            0:       body = '0;
            1:       body = '1;
            default: body = $urandom;
        endcase
        crc = crc8_msb(cfg.crc_seed, {body, 8'h00}, 24);
        if ($urandom_range(0, 1) == 0) begin
            return {body, crc};
        end
        return {body, 8'($urandom)};
    endfunction

    function automatic t_dir_row mk_row(input logic [1:0] func, input logic [7:0] bright,
                                        input logic pin, input logic typed, input logic busy);
        t_dir_row r;
        r = '0;
        r.w.func       = func;
        r.w.brightness = bright;
        r.w.pin_level  = pin;
        r.typed        = typed;
        r.want.line_drive         = 1'b1;
        r.want.line_output_enable = 1'b1;
        r.want.busy_res           = busy;
        return r;
    endfunction

    task automatic send_word(input t_in_word w, input logic typed, input t_out_word want);
        int        gap;
        t_out_word got;
        if (in_sent % 40 == 0) in_mode = $urandom_range(0, 2);
        in_sent++;
        gap = draw_wait(in_mode);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall !== 1'b0);
        got = step_session(w);
        pending_out.push_back(typed ? want : got);
    endtask

    // Ticks the session to its end, with an ignored word slipped in now and then.
    task automatic finish_session();
        t_in_word w;
        while (ph != PH_IDLE) begin
            w.brightness = $urandom_range(0, 255);
            w.pin_level  = $urandom_range(0, 1);
            if ($urandom_range(0, 19) == 0) begin
                w.func = $urandom_range(1, 3);
            end else begin
                w.func = FUNC_TICK;
                if (ph == PH_SAMPLE) begin
                    if (tcnt == 0) reply_plan = make_reply();
                    w.pin_level = reply_plan[31 - tcnt];
                end
                word_count++;
            end
            send_word(w, 1'b0, '0);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge clk);
    endtask

    // Upper data bits beyond each register's width are random and must be dropped.
    task automatic load_settings(input t_cfg s);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_RESET_HIGH;
        cfg_data <= {2'($urandom), s.reset_high_ticks};
        @(posedge clk);
        cfg_idx  <= CFG_START_LOW;
        cfg_data <= {4'($urandom), s.start_low_ticks};
        @(posedge clk);
        cfg_idx  <= CFG_MAX_ATT;
        cfg_data <= {5'($urandom), s.max_attempts};
        @(posedge clk);
        cfg_idx  <= CFG_CRC_SEED;
        cfg_data <= s.crc_seed;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cfg = s;
    endtask

    task automatic note_failure(input string what, input t_out_word want, input t_out_word got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: exp drv=%b oe=%b busy=%b done=%b ok=%b raw=%h type=%h fw=%0d",
                     $realtime, what, want.line_drive, want.line_output_enable, want.busy_res,
                     want.done_res, want.success, want.raw_response, want.lcd_type,
                     want.firmware_version);
            $display("    got drv=%b oe=%b busy=%b done=%b ok=%b raw=%h type=%h fw=%0d",
                     got.line_drive, got.line_output_enable, got.busy_res, got.done_res,
                     got.success, got.raw_response, got.lcd_type, got.firmware_version);
        end
    endtask

    t_out_word want_out;

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (pending_out.size() == 0) begin
                note_failure("unexpected result word", '0, out_word);
            end else begin
                want_out = pending_out.pop_front();
                if (out_word.line_drive !== want_out.line_drive
                        || out_word.line_output_enable !== want_out.line_output_enable
                        || out_word.busy_res !== want_out.busy_res
                        || out_word.done_res !== want_out.done_res
                        || out_word.success !== want_out.success
                        || out_word.raw_response !== want_out.raw_response
                        || out_word.lcd_type !== want_out.lcd_type
                        || out_word.firmware_version !== want_out.firmware_version) begin
                    note_failure("result mismatch", want_out, out_word);
                end
            end
        end
    end

    initial begin : out_side
        int hold;
        int mode;
        int n;
        mode = 0;
        n = 0;
        forever begin
            if (n % 40 == 0) mode = $urandom_range(0, 2);
            n++;
            hold = draw_wait(mode);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
        end
    end

    initial begin : stimulus
        t_dir_row dir_rows[$];
        t_dir_row row;
        t_cfg     fixed_sets[$];
        t_cfg     s;
        t_in_word w;
        int       k;
        int       nsess;

        cfg  = {6'd60, 4'd2, 3'd3, 8'hAC};
        ph   = PH_IDLE;
        tcnt = '0;
        req  = '0;
        txs  = '0;
        rxs  = '0;
        att  = '0;
        drv  = 1'b1;
        den  = 1'b1;

        // Idle ticks and unknown codes change nothing; starts while busy are ignored.
        dir_rows.push_back(mk_row(FUNC_TICK, 8'h00, 1'b0, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(FUNC_NONE, 8'hFF, 1'b1, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(FUNC_TICK, 8'hFF, 1'b1, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(FUNC_BACKLIGHT, 8'hFF, 1'b0, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(FUNC_INFO, 8'h00, 1'b1, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(FUNC_BACKLIGHT, 8'h00, 1'b0, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(FUNC_NONE, 8'h80, 1'b1, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(FUNC_TICK, 8'h7F, 1'b1, 1'b1, 1'b1));
        for (int i = 0; i < 12; i++) begin
            dir_rows.push_back(mk_row(FUNC_TICK, 8'(i * 37), 1'(i), 1'b0, 1'b1));
        end
        dir_rows.push_back(mk_row(FUNC_INFO, 8'h55, 1'b0, 1'b0, 1'b1));

        fixed_sets.push_back({6'd1, 4'd1, 3'd1, 8'h00});
        fixed_sets.push_back({6'd0, 4'd0, 3'd0, 8'hFF});
        fixed_sets.push_back({6'd63, 4'd15, 3'd7, 8'h5A});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_word(row.w, row.typed, row.want);
            word_count++;
        end
        finish_session();

        k = 0;
        while (word_count < 850) begin
            wait_idle();
            if (k < fixed_sets.size()) begin
                s = fixed_sets[k];
            end else begin
                s = {6'($urandom_range(0, 8)), 4'($urandom_range(0, 4)),
                     3'($urandom_range(0, 5)), 8'($urandom)};
            end
            load_settings(s);
            // The slowest setting gets a single session.
            nsess = (k == 2) ? 1 : 4;
            for (int j = 0; j < nsess; j++) begin
                if ($urandom_range(0, 2) == 0) begin
                    w.func       = ($urandom_range(0, 1) == 0) ? FUNC_TICK : FUNC_NONE;
                    w.brightness = $urandom_range(0, 255);
                    w.pin_level  = $urandom_range(0, 1);
                    send_word(w, 1'b0, '0);
                end
                w.func      = ($urandom_range(0, 1) == 0) ? FUNC_INFO : FUNC_BACKLIGHT;
                w.pin_level = $urandom_range(0, 1);
                case ($urandom_range(0, 7))
                    0:       w.brightness = 8'd0;
                    1:       w.brightness = 8'd127;
                    2:       w.brightness = 8'd128;
                    3:       w.brightness = 8'd255;
                    default: w.brightness = $urandom_range(0, 255);
                endcase
                send_word(w, 1'b0, '0);
                word_count++;
                finish_session();
            end
            k++;
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule

### files.f
rtl/owlm_pkg.sv
rtl/owlm_core.sv
rtl/one_wire_lcd_session_master_unit.sv
tb/sv/tb.sv
